@@ rtl/akpd_pkg.sv @@
package akpd_pkg;

    // Field widths of the transaction payloads
    localparam int SAMPLE_W = 10;
    localparam int EVENT_W  = 4;
    localparam int HOLD_W   = 11;
    localparam int IDLE_W   = 7;

    // APB register map
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [1:0] REG_SHORT_PRESS  = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS   = 2'd1;
    localparam logic [1:0] REG_RELEASE_IDLE = 2'd2;

    // Register reset values
    localparam logic [HOLD_W-1:0] SHORT_PRESS_RST  = 11'd50;
    localparam logic [HOLD_W-1:0] LONG_PRESS_RST   = 11'd1000;
    localparam logic [IDLE_W-1:0] RELEASE_IDLE_RST = 7'd50;

    // Counter saturation values
    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;
    localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

    // Command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // Classification windows, bounds exclusive
    localparam logic [SAMPLE_W-1:0] DOWN_LO  = 10'd170;
    localparam logic [SAMPLE_W-1:0] DOWN_HI  = 10'd190;
    localparam logic [SAMPLE_W-1:0] RIGHT_LO = 10'd311;
    localparam logic [SAMPLE_W-1:0] RIGHT_HI = 10'd331;
    localparam logic [SAMPLE_W-1:0] UP_LO    = 10'd600;
    localparam logic [SAMPLE_W-1:0] UP_HI    = 10'd620;
    localparam logic [SAMPLE_W-1:0] LEFT_LO  = 10'd830;
    localparam logic [SAMPLE_W-1:0] LEFT_HI  = 10'd850;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_NONE     = 4'd0;
    localparam logic [EVENT_W-1:0] LONG_OFFSET = 4'd4;

    typedef enum logic [2:0] {
        CLS_IDLE  = 3'd0,
        CLS_UP    = 3'd1,
        CLS_DOWN  = 3'd2,
        CLS_LEFT  = 3'd3,
        CLS_RIGHT = 3'd4
    } btn_cls_t;

    typedef struct packed {
        logic [HOLD_W-1:0] short_press_count;
        logic [HOLD_W-1:0] long_press_count;
        logic [IDLE_W-1:0] release_idle_count;
    } cfg_t;

endpackage

@@ rtl/akpd_if.sv @@
interface akpd_req_if
    import akpd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                command;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output command, output sample, input ready);
    modport sink   (input valid, input command, input sample, output ready);
endinterface

interface akpd_rsp_if
    import akpd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_res;
    logic [EVENT_W-1:0] pending_event;

    modport source (output valid, output event_res, output pending_event, input ready);
    modport sink   (input valid, input event_res, input pending_event, output ready);
endinterface

@@ rtl/akpd_cfg_regs.sv @@
module akpd_cfg_regs
    import akpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_SHORT_PRESS:  cfg_next.short_press_count  = pwdata[HOLD_W-1:0];
                REG_LONG_PRESS:   cfg_next.long_press_count   = pwdata[HOLD_W-1:0];
                REG_RELEASE_IDLE: cfg_next.release_idle_count = pwdata[IDLE_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_press_count  <= SHORT_PRESS_RST;
            cfg_reg.long_press_count   <= LONG_PRESS_RST;
            cfg_reg.release_idle_count <= RELEASE_IDLE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb
    begin
        unique case (paddr[3:2])
            REG_SHORT_PRESS:
                prdata = {{(APB_DATA_W-HOLD_W){1'b0}}, cfg_reg.short_press_count};
            REG_LONG_PRESS:
                prdata = {{(APB_DATA_W-HOLD_W){1'b0}}, cfg_reg.long_press_count};
            REG_RELEASE_IDLE:
                prdata = {{(APB_DATA_W-IDLE_W){1'b0}}, cfg_reg.release_idle_count};
            default:
                prdata = '0;
        endcase
    end

endmodule

@@ rtl/akpd_classify.sv @@
module akpd_classify
    import akpd_pkg::*;
(
    input  logic [SAMPLE_W-1:0] sample,
    output btn_cls_t            cls
);

    // Window compares, first match wins
    always_comb
    begin
        if (sample > DOWN_LO && sample < DOWN_HI)
            cls = CLS_DOWN;
        else if (sample > RIGHT_LO && sample < RIGHT_HI)
            cls = CLS_RIGHT;
        else if (sample > UP_LO && sample < UP_HI)
            cls = CLS_UP;
        else if (sample > LEFT_LO && sample < LEFT_HI)
            cls = CLS_LEFT;
        else
            cls = CLS_IDLE;
    end

endmodule

@@ rtl/akpd_core.sv @@
module akpd_core
    import akpd_pkg::*;
#(
    parameter int ADC_BITS = 10
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    akpd_req_if.sink   req,
    akpd_rsp_if.source rsp
);

    // Samples narrower than the port keep only their low ADC_BITS bits
    localparam logic [SAMPLE_W-1:0] ADC_MASK =
        (ADC_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << ADC_BITS) - 1);

    // Input stage
    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic                s1_cmd_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;

    // Output stage
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [EVENT_W-1:0] ev_reg;
    logic [EVENT_W-1:0] pend_reg;

    // Detector state
    btn_cls_t          button_class_reg, button_class_next;
    logic [HOLD_W-1:0] hold_count_reg, hold_count_next;
    logic [IDLE_W-1:0] idle_count_reg, idle_count_next;
    logic              short_fired_reg, short_fired_next;
    logic              long_fired_reg, long_fired_next;
    logic [EVENT_W-1:0] latched_reg, latched_next;

    logic               advance;
    logic               take;
    btn_cls_t           cls;
    logic [HOLD_W-1:0]  hold_base;
    logic               flags_clear;
    logic               sf_cur, lf_cur;
    logic               fire_short, fire_long;
    logic [EVENT_W-1:0] ev_next;

    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign take      = req.valid && req.ready;
    assign req.ready = !s1_valid_reg || advance;

    assign s1_valid_next  = take || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !rsp.ready);

    akpd_classify u_classify (
        .sample (s1_sample_reg & ADC_MASK),
        .cls    (cls)
    );

    // Counter and flag update for one sample
    always_comb
    begin
        if (cls == CLS_IDLE)
        begin
            idle_count_next = (idle_count_reg < IDLE_MAX) ? idle_count_reg + 1'b1
                                                          : idle_count_reg;
            hold_base       = '0;
        end
        else
        begin
            idle_count_next = '0;
            hold_base       = hold_count_reg;
        end

        flags_clear = idle_count_next > cfg.release_idle_count;
        sf_cur      = short_fired_reg && !flags_clear;
        lf_cur      = long_fired_reg && !flags_clear;

        if (button_class_reg != cls)
            hold_count_next = '0;
        else if (hold_base < HOLD_MAX)
            hold_count_next = hold_base + 1'b1;
        else
            hold_count_next = hold_base;

        fire_short = (hold_count_next > cfg.short_press_count) && !sf_cur;
        fire_long  = !fire_short && (hold_count_next > cfg.long_press_count) && !lf_cur;

        short_fired_next  = sf_cur || fire_short;
        long_fired_next   = lf_cur || fire_long;
        button_class_next = cls;

        if (cls == CLS_IDLE)
            ev_next = EV_NONE;
        else if (fire_short)
            ev_next = {1'b0, cls};
        else if (fire_long)
            ev_next = {1'b0, cls} + LONG_OFFSET;
        else
            ev_next = EV_NONE;

        latched_next = (latched_reg == EV_NONE) ? ev_next : latched_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            button_class_reg <= CLS_IDLE;
            hold_count_reg   <= '0;
            idle_count_reg   <= '0;
            short_fired_reg  <= 1'b0;
            long_fired_reg   <= 1'b0;
            latched_reg      <= EV_NONE;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                if (s1_cmd_reg == CMD_READ)
                begin
                    latched_reg <= EV_NONE;
                end
                else
                begin
                    button_class_reg <= button_class_next;
                    hold_count_reg   <= hold_count_next;
                    idle_count_reg   <= idle_count_next;
                    short_fired_reg  <= short_fired_next;
                    long_fired_reg   <= long_fired_next;
                    latched_reg      <= latched_next;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_cmd_reg    <= req.command;
            s1_sample_reg <= req.sample;
        end
        if (advance)
        begin
            ev_reg   <= (s1_cmd_reg == CMD_READ) ? EV_NONE : ev_next;
            pend_reg <= latched_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.event_res     = ev_reg;
    assign rsp.pending_event = pend_reg;

`ifndef ASSERT_OFF
    // A running idle count means the last sample was idle
    a_idle_cls: assert property (@(posedge clk) disable iff (!rst_n)
        idle_count_reg != '0 |-> button_class_reg == CLS_IDLE)
        else $error("idle count running with a button class held");

    // While idle, the hold count never exceeds one
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        idle_count_reg != '0 |-> hold_count_reg <= HOLD_W'(1))
        else $error("hold count grew during idle run");

    // A read transaction empties the latch
    a_read_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_cmd_reg == CMD_READ |=> latched_reg == EV_NONE)
        else $error("pending event not cleared by read");
`endif

endmodule

@@ rtl/analog_keypad_press_detector_unit.sv @@
// Pipeline: an accepted request transaction passes the input stage, then the response
//   register, and the response is held there while rsp.ready is low.
// Throughput: one transaction per cycle while rsp.ready does not hold the response; all
//   compares and counter updates sit between the input stage and the response register.
// Reset: rst_n is asynchronous, active low; it clears the pipeline valids, the detector
//   state and the latch, and loads the registers with 50, 1000 and 50.
module analog_keypad_press_detector_unit
    import akpd_pkg::*;
#(
    parameter int ADC_BITS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    akpd_req_if.sink              req,
    akpd_rsp_if.source            rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t cfg;

    akpd_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    akpd_core #(
        .ADC_BITS (ADC_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

endmodule
